// ===== src/kcc_pkg.sv =====
// Shared types and constants for the key click classifier.
package kcc_pkg;

    localparam int KEY_W     = 4;
    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = 2'd1;

    localparam logic [CNT_W-1:0] LONG_PRESS_RESET    = 8'd100;
    localparam logic [CNT_W-1:0] DOUBLE_WINDOW_RESET = 8'd35;
    localparam logic [CNT_W-1:0] CNT_MAX             = 8'd255;

    // Per-key debounce states
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_CONFIRM = 2'd1;
    localparam logic [1:0] ST_HELD    = 2'd2;

    // Events found by one key lane on one tick
    typedef struct packed {
        logic single_click;
        logic double_click;
        logic long_press;
    } kcc_flags_t;

    // Thresholds handed to every lane
    typedef struct packed {
        logic [CNT_W-1:0] long_press_ticks;
        logic [CNT_W-1:0] double_window_ticks;
    } kcc_cfg_t;

endpackage

// ===== src/kcc_lane.sv =====
// One key lane: debounce machine, hold counter and double-click window.
module kcc_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick,
    input  logic                pressed,
    input  kcc_pkg::kcc_cfg_t   cfg,
    output kcc_pkg::kcc_flags_t flags
);
    import kcc_pkg::*;

    logic [1:0]       state_reg,   state_next;
    logic [CNT_W-1:0] hold_reg,    hold_next;
    logic             pending_reg, pending_next;
    logic [CNT_W-1:0] window_reg,  window_next;

    logic             pend_mid;
    logic [CNT_W-1:0] win_mid;
    logic [CNT_W-1:0] win_cnt;

    always_comb
    begin
        state_next        = state_reg;
        hold_next         = hold_reg;
        pend_mid          = pending_reg;
        win_mid           = window_reg;
        flags             = '0;
        unique case (state_reg)
            ST_CONFIRM:
            begin
                if (pressed)
                begin
                    state_next = ST_HELD;
                    hold_next  = '0;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_HELD:
            begin
                if (pressed)
                begin
                    if (hold_reg != CNT_MAX)
                        hold_next = hold_reg + 1'b1;
                end
                else
                begin
                    if (hold_reg > cfg.long_press_ticks)
                    begin
                        flags.long_press = 1'b1;
                    end
                    else if (!pending_reg)
                    begin
                        pend_mid = 1'b1;
                        win_mid  = '0;
                    end
                    else
                    begin
                        flags.double_click = 1'b1;
                        pend_mid           = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                // idle, and the unused code behaves as idle
                state_next = pressed ? ST_CONFIRM : ST_IDLE;
            end
        endcase

        // window counts on the tick it opens
        win_cnt      = (win_mid != CNT_MAX) ? win_mid + 1'b1 : win_mid;
        pending_next = pend_mid;
        window_next  = win_mid;
        if (pend_mid)
        begin
            window_next = win_cnt;
            if (win_cnt >= cfg.double_window_ticks)
            begin
                flags.single_click = 1'b1;
                pending_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            hold_reg    <= '0;
            pending_reg <= 1'b0;
            window_reg  <= '0;
        end
        else if (tick)
        begin
            state_reg   <= state_next;
            hold_reg    <= hold_next;
            pending_reg <= pending_next;
            window_reg  <= window_next;
        end
    end

endmodule

// ===== src/kcc_merge.sv =====
// Gathers lane events into the three masks and holds them in the output register.
module kcc_merge #(
    parameter int NUM_KEYS = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         tick,
    input  kcc_pkg::kcc_flags_t          flags [NUM_KEYS],
    output logic                         load_ok,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [kcc_pkg::KEY_W-1:0]    single_mask,
    output logic [kcc_pkg::KEY_W-1:0]    double_mask,
    output logic [kcc_pkg::KEY_W-1:0]    long_mask
);
    import kcc_pkg::*;

    logic             valid_reg;
    logic [KEY_W-1:0] single_reg, double_reg, long_reg;
    logic [KEY_W-1:0] single_next, double_next, long_next;

    // lanes past the field width are dropped, missing lanes read as zero
    always_comb
    begin
        single_next = '0;
        double_next = '0;
        long_next   = '0;
        for (int k = 0; k < KEY_W; k++)
        begin
            if (k < NUM_KEYS)
            begin
                single_next[k] = flags[k].single_click;
                double_next[k] = flags[k].double_click;
                long_next[k]   = flags[k].long_press;
            end
        end
    end

    assign load_ok = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load_ok)
            valid_reg <= tick;
    end

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            single_reg <= single_next;
            double_reg <= double_next;
            long_reg   <= long_next;
        end
    end

    assign out_valid   = valid_reg;
    assign single_mask = single_reg;
    assign double_mask = double_reg;
    assign long_mask   = long_reg;

endmodule

// ===== src/key_click_classifier_unit.sv =====
// Top level of the key click classifier: config registers, key lanes, merge stage.
//
// Each transfer on the key channel is one tick: the sampled active-low key
// levels. Every key has its own lane (debounce machine, saturating hold
// counter, double-click window) and all lanes update in the same cycle, so a
// tick is taken every clock while key_stall is low, and its result is in the
// output register in the cycle after. Only a full output register whose result
// is stalled holds ticks back; key_stall then follows click_stall.
// Results are one-tick pulses per key: single click when a window runs out,
// double click on the second short release inside a window, long press on a
// release after a hold above long_press_ticks. Keys beyond the fourth see a
// pressed level and their events do not reach the 4-bit masks. Config
// writes (index 0 long_press_ticks, index 1 double_window_ticks, others
// ignored) are always taken and should only be made while the block is idle.
module key_click_classifier_unit #(
    parameter int NUM_KEYS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // key channel
    input  logic                              key_valid,
    output logic                              key_stall,
    input  logic [kcc_pkg::KEY_W-1:0]         key_levels,
    // click channel
    output logic                              click_valid,
    input  logic                              click_stall,
    output logic [kcc_pkg::KEY_W-1:0]         single_click_mask,
    output logic [kcc_pkg::KEY_W-1:0]         double_click_mask,
    output logic [kcc_pkg::KEY_W-1:0]         long_press_mask,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kcc_pkg::CNT_W-1:0]         cfg_data
);
    import kcc_pkg::*;

    kcc_cfg_t   cfg_reg;
    kcc_flags_t lane_flags [NUM_KEYS];
    logic       load_ok;
    logic       tick;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks    <= LONG_PRESS_RESET;
            cfg_reg.double_window_ticks <= DOUBLE_WINDOW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LONG_PRESS:    cfg_reg.long_press_ticks    <= cfg_data;
                REG_DOUBLE_WINDOW: cfg_reg.double_window_ticks <= cfg_data;
                default:           ;
            endcase
        end
    end

    // a tick transfer happens when the output register can take its result
    assign key_stall = !load_ok;
    assign tick      = key_valid && load_ok;

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        logic pressed;
        if (k < KEY_W)
        begin : g_in
            assign pressed = !key_levels[k];
        end
        else
        begin : g_none
            assign pressed = 1'b1;
        end

        kcc_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .tick    (tick),
            .pressed (pressed),
            .cfg     (cfg_reg),
            .flags   (lane_flags[k])
        );
    end

    kcc_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick),
        .flags       (lane_flags),
        .load_ok     (load_ok),
        .out_valid   (click_valid),
        .out_stall   (click_stall),
        .single_mask (single_click_mask),
        .double_mask (double_click_mask),
        .long_mask   (long_press_mask)
    );

endmodule
